@@ hw/rtl/local_minimum_detector_3x3_top_defines.svh @@
// assertion macros shared by the checker
`ifndef LOCAL_MINIMUM_DETECTOR_3X3_TOP_DEFINES_SVH
`define LOCAL_MINIMUM_DETECTOR_3X3_TOP_DEFINES_SVH
// implication checked every clock, quiet in reset
`define LMD_ASSERT_IMP(label, rst_sig, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("lmd check failed");
// next-cycle implication
`define LMD_ASSERT_NXT(label, rst_sig, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("lmd check failed");
`endif

@@ hw/rtl/lmd_pkg.sv @@
// shared types and constants for the local minimum detector
package lmd_pkg;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS = 1'd1;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] pixel_value;
  } lmd_in_t;

  typedef struct packed {
    logic [6:0]         min_row;
    logic [6:0]         min_col;
    logic signed [15:0] min_value;
  } lmd_out_t;

  // one window column and the candidate it decides, from front to back
  typedef struct packed {
    logic signed [15:0] top;
    logic signed [15:0] mid;
    logic signed [15:0] bot;
    logic               cand;     // candidate row is inside the frame
    logic [6:0]         cr;
    logic [6:0]         cc;
    logic               row_first;
    logic               row_last;
    logic               col_first;
    logic               col_last;
  } lmd_col_t;
endpackage

@@ hw/rtl/lmd_front.sv @@
// front end: frame counters, line stores and window column fetch
module lmd_front import lmd_pkg::*; #(
  parameter int unsigned MAX_DIM = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  lmd_in_t               in_item,
  output logic                  in_ready,
  output logic                  col_valid,
  output lmd_col_t              col,
  input  logic                  col_ready
);
  localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DW = $clog2(MAX_DIM + 2);
  localparam logic [DW-1:0] MAXD = DW'(MAX_DIM);

  logic [CFG_DATA_W-1:0] num_rows, num_cols;
  logic [DW-1:0] rows, cols;
  logic [DW-1:0] in_row, in_col, drain_count;
  logic frame_full;
  logic signed [15:0] upper_line [MAX_DIM];
  logic signed [15:0] middle_line [MAX_DIM];

  function automatic logic [DW-1:0] eff(input logic [CFG_DATA_W-1:0] v);
    logic [DW+CFG_DATA_W-1:0] w;
    w = (DW+CFG_DATA_W)'(v);
    if (v == '0) return DW'(1);
    if (w > (DW+CFG_DATA_W)'(MAX_DIM)) return MAXD;
    return DW'(v);
  endfunction

  assign rows = eff(num_rows);
  assign cols = eff(num_cols);

  // output register of the front stage
  logic stage_ok;
  assign stage_ok = !col_valid || col_ready;
  assign in_ready = stage_ok;

  logic take, use_it;
  logic [DW-1:0] vr, c, cr_w, cc_w;
  logic signed [15:0] nv;
  logic [AW-1:0] addr;
  assign take   = in_valid && in_ready;
  assign use_it = take && (frame_full == (in_item.cmd == CMD_DRAIN));

  always_comb begin
    if (!frame_full) begin
      vr = in_row; c = in_col; nv = in_item.pixel_value;
    end else if (drain_count < cols) begin
      vr = rows; c = drain_count; nv = '0;
    end else begin
      vr = rows + DW'(1); c = '0; nv = '0;
    end
    if (c >= cols) c = '0;
    if (c != '0) begin
      cr_w = vr - DW'(1); cc_w = c - DW'(1);
    end else begin
      cr_w = vr - DW'(2); cc_w = cols - DW'(1);
    end
  end
  assign addr = AW'(c);

  logic cand;
  assign cand = (c != '0) ? (vr >= DW'(1) && cr_w < rows)
                          : (vr >= DW'(2) && cr_w < rows);

  always_ff @(posedge clk) begin
    if (use_it) begin
      upper_line[addr]  <= middle_line[addr];
      middle_line[addr] <= nv;
      col.top <= upper_line[addr];
      col.mid <= middle_line[addr];
      col.bot <= nv;
      col.cand <= cand;
      col.cr  <= 7'(cr_w);
      col.cc  <= 7'(cc_w);
      col.row_first <= (cr_w == '0);
      col.row_last  <= (cr_w == rows - DW'(1));
      col.col_first <= (cc_w == '0);
      col.col_last  <= (cc_w == cols - DW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= 8'd128; num_cols <= 8'd128;
      in_row <= '0; in_col <= '0; drain_count <= '0; frame_full <= 1'b0;
      col_valid <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_NUM_ROWS) num_rows <= cfg_data;
      if (cfg_addr == REG_NUM_COLS) num_cols <= cfg_data;
      in_row <= '0; in_col <= '0; drain_count <= '0; frame_full <= 1'b0;
      col_valid <= 1'b0;
    end else begin
      if (stage_ok) col_valid <= use_it;
      if (use_it && !frame_full) begin
        if (in_col + DW'(1) >= cols) begin
          in_col <= '0;
          if (in_row + DW'(1) >= rows) begin
            in_row <= '0; frame_full <= 1'b1; drain_count <= '0;
          end else in_row <= in_row + DW'(1);
        end else in_col <= in_col + DW'(1);
      end else if (use_it) begin
        if (drain_count + DW'(1) > cols) begin
          drain_count <= '0; frame_full <= 1'b0;
        end else drain_count <= drain_count + DW'(1);
      end
    end
  end
endmodule

@@ hw/rtl/lmd_fifo.sv @@
// short queue between front and back
module lmd_fifo import lmd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     flush,
  input  logic     wr_valid,
  input  lmd_col_t wr_data,
  output logic     wr_ready,
  output logic     rd_valid,
  output lmd_col_t rd_data,
  input  logic     rd_ready
);
  lmd_col_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic wr, rd;
  assign wr_ready = cnt != 3'd4;
  assign rd_valid = cnt != 3'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rp];
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd);
    end
  end
endmodule

@@ hw/rtl/lmd_back.sv @@
// back end: 3x3 window shift, neighbour compare and result register
module lmd_back import lmd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     flush,
  input  logic     col_valid,
  input  lmd_col_t col,
  output logic     col_ready,
  output logic     empty,
  output lmd_out_t result,
  input  logic     pop
);
  logic signed [15:0] w [9];
  logic full_q;
  logic adv;
  assign empty = !full_q;
  assign col_ready = !full_q || pop;
  assign adv = col_valid && col_ready;

  // window after the shift; compares use it
  logic signed [15:0] n [9];
  always_comb begin
    n[0] = w[1]; n[1] = w[2]; n[2] = col.top;
    n[3] = w[4]; n[4] = w[5]; n[5] = col.mid;
    n[6] = w[7]; n[7] = w[8]; n[8] = col.bot;
  end

  logic is_min;
  always_comb begin
    logic ur, lr, lc, rc;
    ur = !col.row_first; lr = !col.row_last;
    lc = !col.col_first; rc = !col.col_last;
    is_min = 1'b1;
    if (ur && lc && n[0] < n[4]) is_min = 1'b0;
    if (ur &&       n[1] < n[4]) is_min = 1'b0;
    if (ur && rc && n[2] < n[4]) is_min = 1'b0;
    if (lc &&       n[3] < n[4]) is_min = 1'b0;
    if (rc &&       n[5] < n[4]) is_min = 1'b0;
    if (lr && lc && n[6] < n[4]) is_min = 1'b0;
    if (lr &&       n[7] < n[4]) is_min = 1'b0;
    if (lr && rc && n[8] < n[4]) is_min = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      for (int i = 0; i < 9; i++) w[i] <= '0;
    end else if (adv) begin
      for (int i = 0; i < 9; i++) w[i] <= n[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.min_row   <= col.cr;
      result.min_col   <= col.cc;
      result.min_value <= n[4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) full_q <= 1'b0;
    else if (adv) full_q <= col.cand && is_min;
    else if (pop) full_q <= 1'b0;
  end
endmodule

@@ hw/rtl/local_minimum_detector_3x3_top.sv @@
// top level of the 3x3 local minimum detector
// Pixels of a frame enter in raster order as beats on push/full with cmd=0;
// after the frame, num_cols+1 beats with cmd=1 drain the last row and pixel.
// A pixel is decided num_cols+1 beats after it arrives; a result beat appears
// on empty/pop when the pixel has no strictly smaller in-frame neighbour.
// Throughput is one beat per clock while nothing stalls: the front fetches a window
// column from the two line stores into its output register, a four-entry queue
// carries it to the back end, which shifts the window and runs the eight compares
// into a single result register. An accepted beat passes through the front
// output register, the queue and the result register on the way to its result.
// Reset (rst, synchronous) sets both dimensions to 128, restarts the frame
// counters and empties queue and result; line store contents stay undefined.
// A configuration write (we, addr, wdata) also restarts the frame and must
// happen only while the block is idle.
// When the receiver stalls, the result register, queue and front output register
// fill and then full rises; no beat is lost. Beats outside the frame sequence are dropped.
module local_minimum_detector_3x3_top import lmd_pkg::*; #(
  parameter int unsigned MAX_DIM = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_ADDR_W-1:0] addr,
  input  logic [CFG_DATA_W-1:0] wdata,
  input  logic                  push,
  input  lmd_in_t               in_data,
  output logic                  full,
  output logic                  empty,
  output lmd_out_t              out_data,
  input  logic                  pop
);
  logic f_valid, f_ready, in_ready, q_valid, q_ready;
  lmd_col_t f_col, q_col;

  lmd_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk, .rst, .cfg_we(we), .cfg_addr(addr), .cfg_data(wdata),
    .in_valid(push), .in_item(in_data), .in_ready,
    .col_valid(f_valid), .col(f_col), .col_ready(f_ready)
  );
  assign full = !in_ready;

  lmd_fifo u_fifo (
    .clk, .rst, .flush(we), .wr_valid(f_valid), .wr_data(f_col), .wr_ready(f_ready),
    .rd_valid(q_valid), .rd_data(q_col), .rd_ready(q_ready)
  );

  lmd_back u_back (
    .clk, .rst, .flush(we), .col_valid(q_valid), .col(q_col), .col_ready(q_ready),
    .empty, .result(out_data), .pop
  );
endmodule

@@ hw/rtl/lmd_checker.sv @@
// port-level checks for the detector, bound to the top level
`include "local_minimum_detector_3x3_top_defines.svh"
module lmd_checker import lmd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     we,
  input logic     push,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input lmd_out_t out_data
);
  // a result column never exceeds the largest index
  `LMD_ASSERT_IMP(a_col_range, rst, !empty, out_data.min_col <= 7'd127)
  // a waiting result that is not taken stays put
  `LMD_ASSERT_NXT(a_hold, rst, !empty && !pop && !we, !empty && $stable(out_data))
  // after reset nothing is waiting
  `LMD_ASSERT_NXT(a_reset, 1'b0, rst, empty && !full)
  // a configuration write leaves the input open
  `LMD_ASSERT_NXT(a_cfg_clear, rst, we && !push, !full)
endmodule

bind local_minimum_detector_3x3_top lmd_checker u_lmd_checker (
  .clk, .rst, .we, .push, .full, .empty, .pop, .out_data
);

@@ dv/tb_top.sv @@
// self-checking testbench for the 3x3 local minimum detector top level
module tb_top;
  import lmd_pkg::*;

  localparam int MAX_DIM = 128;
  localparam int QUIET_LIMIT = 5000;

  logic clk;
  logic rst;
  logic we;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;
  logic push;
  lmd_in_t in_data;
  logic full;
  logic empty;
  lmd_out_t out_data;
  logic pop;

  local_minimum_detector_3x3_top #(.MAX_DIM(MAX_DIM)) i_dut (
    .clk(clk), .rst(rst), .we(we), .addr(addr), .wdata(wdata),
    .push(push), .in_data(in_data), .full(full),
    .empty(empty), .out_data(out_data), .pop(pop)
  );

  // predictor state
  int rows_reg;
  int cols_reg;
  logic signed [15:0] upper_mem [MAX_DIM];
  logic signed [15:0] middle_mem [MAX_DIM];
  logic signed [15:0] win [9];
  int pos_row;
  int pos_col;
  int drains_seen;
  bit frame_done;

  lmd_out_t minima_q[$];
  int errors;
  int send_idle_pct;
  int pop_idle_pct;
  int hold_req;
  int quiet_cycles;

  function automatic int eff_dim(int v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void restart_frame();
    pos_row = 0;
    pos_col = 0;
    drains_seen = 0;
    frame_done = 0;
    foreach (win[i]) win[i] = '0;
  endfunction

  // advance the window by one beat and return a local minimum if one is decided
  function automatic bit find_minimum(lmd_in_t beat, output lmd_out_t res);
    int rows;
    int cols;
    int vr;
    int c;
    int cr;
    int cc;
    int nr;
    int nc;
    logic signed [15:0] nv;
    logic signed [15:0] ctr;
    bit is_min;
    rows = eff_dim(rows_reg);
    cols = eff_dim(cols_reg);
    res = '0;
    if (!frame_done && beat.cmd == CMD_DRAIN) return 0;
    if (frame_done && beat.cmd == CMD_PIXEL) return 0;
    if (!frame_done) begin
      vr = pos_row;
      c = pos_col;
      nv = beat.pixel_value;
    end else begin
      if (drains_seen < cols) begin
        vr = rows;
        c = drains_seen;
      end else begin
        vr = rows + 1;
        c = 0;
      end
      nv = '0;
    end
    if (c < 0 || c >= cols) c = 0;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = upper_mem[c];
    win[5] = middle_mem[c];
    win[8] = nv;
    upper_mem[c] = middle_mem[c];
    middle_mem[c] = nv;
    if (c >= 1) begin
      cr = vr - 1;
      cc = c - 1;
    end else begin
      cr = vr - 2;
      cc = cols - 1;
    end
    if (!frame_done) begin
      pos_col++;
      if (pos_col >= cols) begin
        pos_col = 0;
        pos_row++;
        if (pos_row >= rows) begin
          pos_row = 0;
          frame_done = 1;
          drains_seen = 0;
        end
      end
    end else begin
      drains_seen++;
      if (drains_seen > cols) begin
        drains_seen = 0;
        frame_done = 0;
      end
    end
    if (cr < 0 || cr >= rows) return 0;
    ctr = win[4];
    is_min = 1;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = cr + dr;
        nc = cc + dc;
        if (dr == 0 && dc == 0) continue;
        if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
        if (win[(dr+1)*3 + dc + 1] < ctr) is_min = 0;
      end
    end
    if (!is_min) return 0;
    res.min_row = cr[6:0];
    res.min_col = cc[6:0];
    res.min_value = ctr;
    return 1;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin
    lmd_out_t want;
    if (!rst && pop && !empty) begin
      if (minima_q.size() == 0) begin
        $display("%0t: result expected none actual %p", $time, out_data);
        errors++;
      end else begin
        want = minima_q.pop_front();
        if (out_data.min_row !== want.min_row) begin
          $display("%0t: min_row expected %0d actual %0d", $time, want.min_row,
                   out_data.min_row);
          errors++;
        end
        if (out_data.min_col !== want.min_col) begin
          $display("%0t: min_col expected %0d actual %0d", $time, want.min_col,
                   out_data.min_col);
          errors++;
        end
        if (out_data.min_value !== want.min_value) begin
          $display("%0t: min_value expected %0d actual %0d", $time,
                   want.min_value, out_data.min_value);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 0;
      end else begin
        pop <= ($urandom_range(0, 99) >= pop_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL local_minimum_detector_3x3_top");
        $finish;
      end
    end
  end

  task automatic send_beat(logic cmd, logic signed [15:0] value);
    lmd_in_t beat;
    lmd_out_t res;
    int gap;
    beat.cmd = cmd;
    beat.pixel_value = value;
    push <= 1;
    in_data <= beat;
    do @(posedge clk); while (full);
    if (find_minimum(beat, res)) minima_q.push_back(res);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      push <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 0;
    @(posedge clk);
    while (minima_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    we <= 1;
    addr <= idx;
    wdata <= val;
    @(posedge clk);
    we <= 0;
    if (idx == REG_NUM_ROWS) rows_reg = val;
    else cols_reg = val;
    restart_frame();
  endtask

  function automatic logic signed [15:0] pick_pixel(int flavor);
    case (flavor)
      0: return 16'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // whole frame then the drain beats
  task automatic send_frame(int flavor);
    int n;
    n = eff_dim(rows_reg) * eff_dim(cols_reg);
    for (int i = 0; i < n; i++) send_beat(CMD_PIXEL, pick_pixel(flavor));
    for (int i = 0; i <= eff_dim(cols_reg); i++) send_beat(CMD_DRAIN, 16'($urandom()));
  endtask

  task automatic test_directed();
    write_reg(REG_NUM_ROWS, 8'd1);
    write_reg(REG_NUM_COLS, 8'd1);
    send_beat(CMD_DRAIN, 16'sh1234);   // drain before the frame is ignored
    send_beat(CMD_PIXEL, 16'sh8000);
    send_beat(CMD_PIXEL, 16'sh0005);   // dropped, frame already full
    send_beat(CMD_DRAIN, 16'sh0);
    send_beat(CMD_DRAIN, 16'sh0);
    write_reg(REG_NUM_ROWS, 8'd2);
    write_reg(REG_NUM_COLS, 8'd3);
    send_beat(CMD_PIXEL, 16'sh7fff);
    send_beat(CMD_PIXEL, 16'sh8000);
    send_beat(CMD_PIXEL, 16'sh7fff);
    send_beat(CMD_PIXEL, 16'sh0000);   // ties with its neighbour in the row
    send_beat(CMD_PIXEL, 16'sh0000);
    send_beat(CMD_PIXEL, 16'sh0000);
    for (int i = 0; i < 4; i++) send_beat(CMD_DRAIN, 16'shffff);
    // zero acts as one
    write_reg(REG_NUM_ROWS, 8'd0);
    write_reg(REG_NUM_COLS, 8'd0);
    send_beat(CMD_PIXEL, 16'sh7fff);
    send_beat(CMD_DRAIN, 16'sh0);
    send_beat(CMD_DRAIN, 16'sh0);
  endtask

  task automatic test_extreme_sizes();
    // above the maximum acts as the maximum
    write_reg(REG_NUM_ROWS, 8'd255);
    write_reg(REG_NUM_COLS, 8'd1);
    send_frame(0);
    write_reg(REG_NUM_ROWS, 8'd2);
    write_reg(REG_NUM_COLS, 8'd128);
    send_frame(2);
    write_reg(REG_NUM_ROWS, 8'd128);
    write_reg(REG_NUM_COLS, 8'd2);
    send_frame(1);
  endtask

  task automatic test_random_frames(int beats, int s_idle, int p_idle);
    int sent;
    int pick;
    int n;
    int cut;
    send_idle_pct = s_idle;
    pop_idle_pct = p_idle;
    sent = 0;
    while (sent < beats) begin
      write_reg(REG_NUM_ROWS, 8'($urandom_range(1, 8)));
      write_reg(REG_NUM_COLS, 8'($urandom_range(1, 8)));
      pick = $urandom_range(0, 9);
      n = eff_dim(rows_reg) * eff_dim(cols_reg);
      if (pick == 0) begin
        // broken frame, cut off by a restart
        cut = $urandom_range(1, n);
        for (int i = 0; i < cut; i++) send_beat(CMD_PIXEL, 16'($urandom()));
        sent += cut;
      end else begin
        if (pick == 1) send_beat(CMD_DRAIN, 16'($urandom()));
        for (int i = 0; i < n; i++) send_beat(CMD_PIXEL, pick_pixel($urandom_range(0, 2)));
        if (pick == 2) send_beat(CMD_PIXEL, 16'($urandom()));
        for (int i = 0; i <= eff_dim(cols_reg); i++) send_beat(CMD_DRAIN, 16'($urandom()));
        sent += n + eff_dim(cols_reg) + 1;
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    pop_idle_pct = 0;
    write_reg(REG_NUM_ROWS, 8'd6);
    write_reg(REG_NUM_COLS, 8'd8);
    hold_req = 400;
    send_frame(0);
  endtask

  initial begin
    errors = 0;
    hold_req = 0;
    send_idle_pct = 29;
    pop_idle_pct = 74;
    rst = 1;
    we = 0;
    addr = '0;
    wdata = '0;
    push = 0;
    in_data = '0;
    rows_reg = 128;
    cols_reg = 128;
    foreach (upper_mem[i]) upper_mem[i] = '0;
    foreach (middle_mem[i]) middle_mem[i] = '0;
    restart_frame();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_extreme_sizes();
    test_random_frames(300, 29, 74);
    test_random_frames(300, 74, 29);
    test_backpressure();
    test_random_frames(200, 0, 0);
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS local_minimum_detector_3x3_top");
    end else begin
      $display("FAIL local_minimum_detector_3x3_top");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lmd_pkg.sv
hw/rtl/lmd_front.sv
hw/rtl/lmd_fifo.sv
hw/rtl/lmd_back.sv
hw/rtl/local_minimum_detector_3x3_top.sv
hw/rtl/lmd_checker.sv
dv/tb_top.sv
